[design/rcpwd_pkg.sv]
// rcpwd_pkg: shared types and constants of the rc pulse width decoder
// used by rcpwd_scale and rc_pulse_width_decoder; depends on nothing else
package rcpwd_pkg;

  // timing and channel defaults
  localparam int TICKS_PER_US_DEF = 84;
  localparam int NUM_CHANNELS     = 4;

  // channel slots addressable by the 2-bit channel field
  localparam int CH_SLOTS = 4;
  localparam int CH_W     = 2;

  // configuration registers: min/max pair per channel slot
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // result value and quotient width
  localparam int VAL_W = 32;

  // per-request tag that travels beside the arithmetic pipeline
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] lo;
    logic             neg;
  } tag_t;

endpackage

[design/rcpwd_scale.sv]
// rcpwd_scale: floor(mag * t / span) for t up to the tick count of one millisecond,
// two 16-bit quotient digits, each a reciprocal multiply with one correction step
// depends on rcpwd_pkg
module rcpwd_scale #(
  parameter int TICKS_PER_US = rcpwd_pkg::TICKS_PER_US_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_vld,
  input  rcpwd_pkg::tag_t                   in_tag,
  input  logic [rcpwd_pkg::VAL_W-1:0]       in_mag,
  input  logic [$clog2(TICKS_PER_US*1000+1)-1:0] in_t,
  output logic                              out_vld,
  output rcpwd_pkg::tag_t                   out_tag,
  output logic [rcpwd_pkg::VAL_W-1:0]       out_quot
);

  localparam int Span = TICKS_PER_US * 1000;
  localparam int TW   = $clog2(Span + 1);
  localparam int QW   = rcpwd_pkg::VAL_W;
  localparam int HW   = QW / 2;
  // a digit dividend stays below span * 2^(HW+1)
  localparam int XW   = TW + HW + 1;
  localparam int MW   = HW + 3;
  localparam int DW   = HW + 1;
  localparam int PW   = XW + MW;
  localparam int NST  = 7;
  localparam logic [63:0]   Recip64 = (64'd1 << XW) / 64'(Span);
  localparam logic [MW-1:0] Recip   = MW'(Recip64);
  localparam logic [XW-1:0] SpanX   = XW'(Span);

  logic [NST-1:0]  vld;
  rcpwd_pkg::tag_t tag [NST];

  logic [XW-1:0] x1_1;
  logic [XW-1:0] pl_1;
  logic [XW-1:0] x1_2;
  logic [XW-1:0] pl_2;
  logic [DW-1:0] e1_2;
  logic [XW-1:0] r1_3;
  logic [XW-1:0] pl_3;
  logic [DW-1:0] e1_3;
  logic [DW-1:0] q1_4;
  logic [XW-1:0] x0_4;
  logic [DW-1:0] q1_5;
  logic [XW-1:0] x0_5;
  logic [DW-1:0] e0_5;
  logic [DW-1:0] q1_6;
  logic [DW-1:0] e0_6;
  logic [XW-1:0] r0_6;
  logic [QW-1:0] quot_7;

  logic [PW-1:0] m1;
  logic [PW-1:0] m0;
  logic          take1;
  logic [XW-1:0] r1c;

  // digit estimates are exact or one low
  assign m1    = PW'(x1_1) * PW'(Recip);
  assign m0    = PW'(x0_4) * PW'(Recip);
  assign take1 = (r1_3 >= SpanX);
  assign r1c   = take1 ? (r1_3 - SpanX) : r1_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= in_tag;
      for (int k = 1; k < NST; k++) begin
        tag[k] <= tag[k-1];
      end
      // split the magnitude into halves, one product each
      x1_1 <= XW'(in_mag[QW-1:HW]) * XW'(in_t);
      pl_1 <= XW'(in_mag[HW-1:0]) * XW'(in_t);
      // high digit
      x1_2 <= x1_1;
      pl_2 <= pl_1;
      e1_2 <= m1[XW +: DW];
      r1_3 <= x1_2 - XW'(e1_2) * SpanX;
      e1_3 <= e1_2;
      pl_3 <= pl_2;
      // correct the high digit, its remainder moves into the low dividend
      q1_4 <= e1_3 + DW'(take1);
      x0_4 <= (r1c << HW) + pl_3;
      // low digit
      q1_5 <= q1_4;
      x0_5 <= x0_4;
      e0_5 <= m0[XW +: DW];
      q1_6 <= q1_5;
      e0_6 <= e0_5;
      r0_6 <= x0_5 - XW'(e0_5) * SpanX;
      quot_7 <= (QW'(q1_6) << HW) + QW'(e0_6) + QW'(r0_6 >= SpanX);
    end
  end

  assign out_vld  = vld[NST-1];
  assign out_tag  = tag[NST-1];
  assign out_quot = quot_7;

endmodule

[design/rc_pulse_width_decoder.sv]
// rc_pulse_width_decoder: four-channel rc servo pulse width decoder, top level
// holds channel edge state, config registers, width check and output register
// depends on rcpwd_pkg and rcpwd_scale
//
// usage:
//   s_* carries edge events: channel, 32-bit capture timestamp, pin level.
//   a falling edge after a recorded high level measures the high time; a time
//   from 0.5 to 2.5 ms gives one result on m_*: channel and signed Q16.16
//   value, the time clamped to 1..2 ms and mapped onto that channel's
//   [min,max]. every other edge only updates the channel state.
//   cfg_we/cfg_index/cfg_data write min (even index) and max (odd index) per
//   channel, taken at once; write only while no request is in flight.
// timing:
//   one request per cycle while a waiting result does not block the output; the
//   path to m_tvalid runs through two front stages (width, then legal check
//   and clamp), seven scaler stages that divide by the tick count of one
//   millisecond with two reciprocal-multiply quotient digits, and the output register.
// reset and stall:
//   rst clears edge state, config registers and all pipeline valid bits.
//   while m_tready is low a waiting result holds; the pipeline keeps moving
//   and s_tready stays high until the next result waits at the scaler output.
module rc_pulse_width_decoder #(
  parameter int TICKS_PER_US = rcpwd_pkg::TICKS_PER_US_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // [1:0] channel, [33:2] timestamp, [34] pin_level, [39:35] zero
  input  logic [39:0]                       s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [1:0] out_channel, [33:2] value, [39:34] zero
  output logic [39:0]                       m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [rcpwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcpwd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int Span = TICKS_PER_US * 1000;
  localparam int TW   = $clog2(Span + 1);
  localparam logic [31:0] SpanW    = 32'(Span);
  localparam logic [31:0] FullHiW  = 32'(TICKS_PER_US * 2000);
  localparam logic [31:0] LegalLoW = 32'(TICKS_PER_US * 500);
  localparam logic [31:0] LegalHiW = 32'(TICKS_PER_US * 2500);
  localparam int ChSlots = rcpwd_pkg::CH_SLOTS;
  localparam int ChW     = rcpwd_pkg::CH_W;
  localparam int VW      = rcpwd_pkg::VAL_W;
  localparam int CFG_IDX_HI = rcpwd_pkg::CFG_IDX_W - 1;

  // configuration registers
  logic [VW-1:0] cfg_min [ChSlots];
  logic [VW-1:0] cfg_max [ChSlots];

  // per-channel edge state
  logic [31:0]        edge_time [ChSlots];
  logic [ChSlots-1:0] prev_level;
  logic [ChSlots-1:0] seen_flag;

  // request fields
  logic [ChW-1:0] in_ch;
  logic [31:0]    in_ts;
  logic           in_lvl;
  logic           ch_ok;
  logic           accept;
  logic           adv;
  logic           out_ld;

  assign in_ch  = s_tdata[1:0];
  assign in_ts  = s_tdata[33:2];
  assign in_lvl = s_tdata[34];
  assign ch_ok  = ({30'd0, in_ch} < 32'(rcpwd_pkg::NUM_CHANNELS));

  // front stage signals
  logic [VW-1:0]   mn;
  logic [VW-1:0]   mx;
  logic            neg_in;
  logic [VW-1:0]   mag_in;
  logic [31:0]     h_in;
  logic            cand_in;

  assign mn      = cfg_min[in_ch];
  assign mx      = cfg_max[in_ch];
  assign neg_in  = ($signed(mx) < $signed(mn));
  // |max - min| fits in 32 bits unsigned
  assign mag_in  = neg_in ? (mn - mx) : (mx - mn);
  assign h_in    = in_ts - edge_time[in_ch];
  assign cand_in = s_tvalid && ch_ok && seen_flag[in_ch] && prev_level[in_ch] && !in_lvl;

  // stage a: width and magnitude
  logic            a_vld;
  logic [31:0]     a_h;
  logic [VW-1:0]   a_mag;
  rcpwd_pkg::tag_t a_tag;

  // stage b: legal check and clamped offset
  logic            b_vld;
  logic [TW-1:0]   b_t;
  logic [VW-1:0]   b_mag;
  rcpwd_pkg::tag_t b_tag;
  logic            a_legal;
  logic [TW-1:0]   a_t;

  // scaler result
  logic            sc_vld;
  rcpwd_pkg::tag_t sc_tag;
  logic [VW-1:0]   sc_quot;

  // output register
  logic            out_vld;
  logic [ChW-1:0]  out_ch;
  logic [VW-1:0]   out_value;
  logic [VW-1:0]   value_next;

  assign out_ld   = !out_vld || m_tready;
  assign adv      = out_ld || !sc_vld;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ChSlots; i++) begin
        cfg_min[i] <= '0;
        cfg_max[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index[0]) begin
        cfg_max[cfg_index[CFG_IDX_HI:1]] <= cfg_data;
      end else begin
        cfg_min[cfg_index[CFG_IDX_HI:1]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ChSlots; i++) begin
        edge_time[i] <= '0;
      end
      prev_level <= '0;
      seen_flag  <= '0;
    end else if (accept && ch_ok) begin
      edge_time[in_ch]  <= in_ts;
      prev_level[in_ch] <= in_lvl;
      seen_flag[in_ch]  <= 1'b1;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_h       <= h_in;
      a_mag     <= mag_in;
      a_tag.ch  <= in_ch;
      a_tag.lo  <= mn;
      a_tag.neg <= neg_in;
    end
  end

  // clamp to 1..2 ms and take the offset from 1 ms
  always_comb begin
    a_legal = (a_h >= LegalLoW) && (a_h <= LegalHiW);
    if (a_h < SpanW) begin
      a_t = '0;
    end else if (a_h > FullHiW) begin
      a_t = TW'(Span);
    end else begin
      a_t = TW'(a_h - SpanW);
    end
  end

  // stage b
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld && a_legal;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_t   <= a_t;
      b_mag <= a_mag;
      b_tag <= a_tag;
    end
  end

  rcpwd_scale #(
    .TICKS_PER_US(TICKS_PER_US)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (b_vld),
    .in_tag  (b_tag),
    .in_mag  (b_mag),
    .in_t    (b_t),
    .out_vld (sc_vld),
    .out_tag (sc_tag),
    .out_quot(sc_quot)
  );

  // truncation toward zero: apply the sign after the unsigned quotient
  assign value_next = sc_tag.neg ? (sc_tag.lo - sc_quot) : (sc_tag.lo + sc_quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_ld) begin
      out_vld <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_ch    <= sc_tag.ch;
      out_value <= value_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {6'd0, out_value, out_ch};

`ifndef ASSERT_OFF
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output not blocked");

  a_seen_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && ch_ok) |=> seen_flag[$past(in_ch)] && (prev_level[$past(in_ch)] == $past(in_lvl)))
    else $error("channel state not updated on request");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (($signed(out_value) >= $signed(cfg_min[out_ch]))
        && ($signed(out_value) <= $signed(cfg_max[out_ch])))
      || (($signed(out_value) <= $signed(cfg_min[out_ch]))
        && ($signed(out_value) >= $signed(cfg_max[out_ch]))))
    else $error("result outside the channel min/max range");
`endif

endmodule

[test/rc_pulse_width_decoder_tb.sv]
// rc_pulse_width_decoder_tb: self-checking bench for the four-channel rc pulse decoder
// drives edge requests and range writes, predicts each command value and compares
// depends on rcpwd_pkg and rc_pulse_width_decoder
module rc_pulse_width_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICKS       = 84;
  localparam int MS_TICKS    = TICKS * 1000;
  localparam int LEGAL_LO    = TICKS * 500;
  localparam int LEGAL_HI    = TICKS * 2500;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 200000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 265;
  localparam int LONG_HOLD   = 300;
  localparam int REG_MIN_OFS = 0;
  localparam int REG_MAX_OFS = 1;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  typedef enum {EXP_NONE, EXP_TYPED, EXP_PRED} exp_kind_t;

  typedef struct {
    logic [rcpwd_pkg::CH_W-1:0]  ch;
    logic [rcpwd_pkg::VAL_W-1:0] value;
  } cmd_t;

  typedef struct {
    logic [rcpwd_pkg::CH_W-1:0] ch;
    logic [31:0]                ts;
    logic                       lvl;
    exp_kind_t                  kind;
    logic [31:0]                val;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [39:0]                     s_tdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [39:0]                     m_tdata;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [rcpwd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rcpwd_pkg::CFG_W-1:0]     cfg_data = '0;

  // predictor state: channel edge history and per-channel output range
  logic [31:0] last_stamp [rcpwd_pkg::CH_SLOTS];
  logic        level_hi   [rcpwd_pkg::CH_SLOTS];
  logic        seen_edge  [rcpwd_pkg::CH_SLOTS];
  logic [31:0] range_lo   [rcpwd_pkg::CH_SLOTS];
  logic [31:0] range_hi   [rcpwd_pkg::CH_SLOTS];

  cmd_t pending_cmds [$];
  cmd_t got_cmd;

  bit gaps_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_go = 1'b0;
  bit hold_taken = 1'b0;
  int rx_wait = 0;
  int fail_cnt = 0;
  int items_sent = 0;
  int results_seen = 0;
  int range_loads = 0;
  int in_stalls = 0;
  int cycle_cnt = 0;

  dir_row_t dir_rows [27] = '{
    '{2'd0, 32'd100,       1'b0, EXP_NONE,  32'h0},          // first edge on a channel
    '{2'd0, 32'd1000,      1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd85000,     1'b0, EXP_TYPED, 32'h0001_0000},  // 1 ms
    '{2'd0, 32'd200000,    1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd368000,    1'b0, EXP_TYPED, 32'h0003_0000},  // 2 ms
    '{2'd0, 32'd400000,    1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd526000,    1'b0, EXP_TYPED, 32'h0002_0000},  // 1.5 ms
    '{2'd0, 32'd700000,    1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd700000,    1'b0, EXP_NONE,  32'h0},          // zero width
    '{2'd0, 32'd800000,    1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd905000,    1'b0, EXP_PRED,  32'h0},
    '{2'd0, 32'd900000,    1'b1, EXP_NONE,  32'h0},
    '{2'd0, 32'd899999,    1'b0, EXP_NONE,  32'h0},          // wraps to a huge width
    '{2'd1, 32'hFFFF_F000, 1'b1, EXP_NONE,  32'h0},
    '{2'd1, 32'h0000_9410, 1'b0, EXP_TYPED, Q_MIN},          // 0.5 ms across the wrap
    '{2'd1, 32'h1000_0000, 1'b1, EXP_NONE,  32'h0},
    '{2'd1, 32'h1003_3450, 1'b0, EXP_TYPED, Q_MAX},          // 2.5 ms
    '{2'd1, 32'h3000_0000, 1'b1, EXP_NONE,  32'h0},
    '{2'd1, 32'h3003_3451, 1'b0, EXP_NONE,  32'h0},          // one tick too long
    '{2'd2, 32'h0000_0000, 1'b1, EXP_NONE,  32'h0},
    '{2'd2, 32'h0001_4820, 1'b0, EXP_TYPED, Q_MAX},          // min above max
    '{2'd2, 32'hFFFF_FFFF, 1'b1, EXP_NONE,  32'h0},
    '{2'd2, 32'h0001_EC2F, 1'b0, EXP_PRED,  32'h0},
    '{2'd3, 32'd5,         1'b1, EXP_NONE,  32'h0},
    '{2'd3, 32'd6,         1'b1, EXP_NONE,  32'h0},          // repeated rising
    '{2'd3, 32'd100006,    1'b0, EXP_TYPED, 32'h0},
    '{2'd3, 32'd150000,    1'b0, EXP_NONE,  32'h0}           // repeated falling
  };

  rc_pulse_width_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // clamp to 1..2 ms, then linear map onto the channel range, truncated toward zero
  function automatic logic [31:0] scale_pulse(input int unsigned ch, input logic [31:0] h);
    longint lo;
    longint hi;
    longint hc;
    longint q;
    logic [63:0] sum;
    lo = longint'($signed(range_lo[ch]));
    hi = longint'($signed(range_hi[ch]));
    hc = longint'(h);
    if (hc < MS_TICKS) hc = MS_TICKS;
    if (hc > 2 * MS_TICKS) hc = 2 * MS_TICKS;
    q = ((hi - lo) * (hc - MS_TICKS)) / longint'(MS_TICKS);
    sum = lo + q;
    return sum[31:0];
  endfunction

  function automatic void decode_edge(input int unsigned ch, input logic [31:0] ts,
                                      input logic lvl, output bit hit, output cmd_t c);
    logic [31:0] h;
    hit = 1'b0;
    c = '{default: '0};
    if (seen_edge[ch] && level_hi[ch] && !lvl) begin
      h = ts - last_stamp[ch];
      if (h >= LEGAL_LO && h <= LEGAL_HI) begin
        hit = 1'b1;
        c.ch = ch[rcpwd_pkg::CH_W-1:0];
        c.value = scale_pulse(ch, h);
      end
    end
    last_stamp[ch] = ts;
    level_hi[ch] = lvl;
    seen_edge[ch] = 1'b1;
  endfunction

  function automatic logic [31:0] pulse_ticks();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 6))
        0: return LEGAL_LO;
        1: return LEGAL_LO - 1;
        2: return MS_TICKS;
        3: return 2 * MS_TICKS;
        4: return LEGAL_HI;
        5: return LEGAL_HI + 1;
        default: return 0;
      endcase
    end
    if (r <= 6) return $urandom_range(LEGAL_LO, LEGAL_HI);
    if (r == 7) return $urandom_range(LEGAL_LO, MS_TICKS);
    if (r == 8) begin
      if ($urandom_range(0, 1)) return $urandom_range(0, LEGAL_LO - 1);
      return $urandom_range(LEGAL_HI + 1, 4 * LEGAL_HI);
    end
    return $urandom;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] e, input logic [31:0] a);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch %0d at cycle %0d: %s expected %h got %h", fail_cnt, cycle_cnt, what, e, a);
  endtask

  task automatic send_edge(input int unsigned ch, input logic [31:0] ts, input logic lvl,
                           input exp_kind_t kind, input logic [31:0] typed);
    bit   hit;
    cmd_t c;
    s_tdata <= {5'b0, lvl, ts, ch[rcpwd_pkg::CH_W-1:0]};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_edge(ch, ts, lvl, hit, c);
    items_sent++;
    if (kind == EXP_TYPED)
      pending_cmds.push_back('{ch[rcpwd_pkg::CH_W-1:0], typed});
    else if (kind == EXP_PRED && hit)
      pending_cmds.push_back(c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // mostly well-formed pulses per channel with random widths, some noise and broken pairs
  task automatic random_edge();
    int unsigned ch;
    int unsigned r;
    logic [31:0] ts;
    logic        lvl;
    ch = $urandom_range(0, rcpwd_pkg::CH_SLOTS - 1);
    r = $urandom_range(0, 19);
    if (r == 0 || !seen_edge[ch]) begin
      ts = $urandom;
      lvl = 1'($urandom_range(0, 1));
    end else if (level_hi[ch]) begin
      ts = last_stamp[ch] + pulse_ticks();
      lvl = (r == 1);
    end else begin
      ts = last_stamp[ch] + ((r == 2) ? $urandom : $urandom_range(1, 400000));
      lvl = (r != 1);
    end
    send_edge(ch, ts, lvl, EXP_PRED, '0);
  endtask

  task automatic load_ranges();
    for (int ch = 0; ch < rcpwd_pkg::CH_SLOTS; ch++) begin
      for (int j = 0; j < 2; j++) begin
        cfg_we <= 1'b1;
        cfg_index <= rcpwd_pkg::CFG_IDX_W'(2 * ch + (j == 0 ? REG_MIN_OFS : REG_MAX_OFS));
        cfg_data <= (j == 0) ? range_lo[ch] : range_hi[ch];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    range_loads++;
  endtask

  task automatic pick_ranges(input bit extremes);
    for (int ch = 0; ch < rcpwd_pkg::CH_SLOTS; ch++) begin
      if (extremes) begin
        range_lo[ch] = $urandom_range(0, 1) ? Q_MIN : Q_MAX;
        range_hi[ch] = (range_lo[ch] == Q_MIN) ? Q_MAX : Q_MIN;
      end else begin
        case ($urandom_range(0, 4))
          0, 1: begin
            range_lo[ch] = $urandom;
            range_hi[ch] = $urandom;
          end
          2: begin
            range_lo[ch] = $urandom;
            range_hi[ch] = range_lo[ch];
          end
          3: begin
            range_lo[ch] = -$urandom_range(0, 32'h0004_0000);
            range_hi[ch] = $urandom_range(0, 32'h0004_0000);
          end
          default: begin
            range_lo[ch] = $urandom;
            range_hi[ch] = Q_MAX;
          end
        endcase
      end
    end
  endtask

  // let every pending command arrive, then give the pipeline time to empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // result side: random stall bursts plus one long hold to back up the pipeline
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      rx_wait <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_wait <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && !s_tready) in_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch("unexpected command, value", '0, m_tdata[33:2]);
      end else begin
        got_cmd = pending_cmds.pop_front();
        if (m_tdata[1:0] !== got_cmd.ch)
          flag_mismatch("out_channel", 32'(got_cmd.ch), 32'(m_tdata[1:0]));
        if (m_tdata[33:2] !== got_cmd.value)
          flag_mismatch("value", got_cmd.value, m_tdata[33:2]);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still pending", cycle_cnt,
               pending_cmds.size());
      $display("** rc_pulse_width_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int ch = 0; ch < rcpwd_pkg::CH_SLOTS; ch++) begin
      last_stamp[ch] = '0;
      level_hi[ch] = 1'b0;
      seen_edge[ch] = 1'b0;
      range_lo[ch] = '0;
      range_hi[ch] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: narrow range, full range, inverted range, flat range at reset value
    range_lo[0] = 32'h0001_0000;
    range_hi[0] = 32'h0003_0000;
    range_lo[1] = Q_MIN;
    range_hi[1] = Q_MAX;
    range_lo[2] = Q_MAX;
    range_hi[2] = Q_MIN;
    load_ranges();
    foreach (dir_rows[k])
      send_edge(dir_rows[k].ch, dir_rows[k].ts, dir_rows[k].lvl, dir_rows[k].kind,
                dir_rows[k].val);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      pick_ranges(p == 3);
      load_ranges();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        gaps_on = (p != PHASES - 1) && ((i / 40) % 3 != 2);
        rx_idle_on <= gaps_on;
        if (p == 1 && i == 100) hold_go <= 1'b1;
        // sender pause mid-phase until every pending command is out
        if (p == 2 && i == 130) wait_idle();
        random_edge();
      end
      wait_idle();
    end

    $display("covered %0d edge requests over %0d range settings, %0d commands checked",
             items_sent, range_loads, results_seen);
    $display("input back-pressure seen on %0d cycles", in_stalls);
    if (fail_cnt == 0) begin
      $display("** rc_pulse_width_decoder: PASSED **");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("** rc_pulse_width_decoder: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rcpwd_pkg.sv
design/rcpwd_scale.sv
design/rc_pulse_width_decoder.sv
test/rc_pulse_width_decoder_tb.sv
